@@ sv/dht_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants, types and the microcode store of the double hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int SLOTS        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_BITS     = 31;
    localparam int MODE_W       = 2;
    localparam int TS_W         = 7;
    localparam int TS_RESET     = 64;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int COUNT_W      = $clog2(SLOTS + 1);
    localparam int WRK_W        = SLOT_W + 1;
    localparam int BIT_W        = $clog2(KEY_BITS);
    localparam int STATE_W      = 2;
    localparam int ENTRY_W      = STATE_W + KEY_BITS + PAYLOAD_BITS;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = APB_AW'(0);

    typedef enum logic [STATE_W-1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } slot_state_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PC_IDLE,
        PC_MOD,
        PC_SETUP,
        PC_READ,
        PC_EVAL,
        PC_RESP
    } pc_t;

    typedef enum logic [2:0] {
        A_LOAD,
        A_MOD,
        A_SETUP,
        A_READ,
        A_EVAL,
        A_RESP
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_REQ,
        C_MOD_MORE,
        C_PRE_FAIL,
        C_PROBE_AGAIN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   jmp;
        pc_t   nxt;
    } ucode_t;

    typedef struct packed {
        logic no_req;
        logic mod_more;
        logic pre_fail;
        logic probe_again;
        logic out_busy;
    } flags_t;

    // jump to jmp when cond holds, else go to nxt
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:  w = '{act: A_LOAD,  cond: C_NO_REQ,      jmp: PC_IDLE, nxt: PC_MOD};
            PC_MOD:   w = '{act: A_MOD,   cond: C_MOD_MORE,    jmp: PC_MOD,  nxt: PC_SETUP};
            PC_SETUP: w = '{act: A_SETUP, cond: C_PRE_FAIL,    jmp: PC_RESP, nxt: PC_READ};
            PC_READ:  w = '{act: A_READ,  cond: C_NEVER,       jmp: PC_READ, nxt: PC_EVAL};
            PC_EVAL:  w = '{act: A_EVAL,  cond: C_PROBE_AGAIN, jmp: PC_READ, nxt: PC_RESP};
            PC_RESP:  w = '{act: A_RESP,  cond: C_OUT_BUSY,    jmp: PC_RESP, nxt: PC_IDLE};
            default:  w = '{act: A_LOAD,  cond: C_NEVER,       jmp: PC_IDLE, nxt: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [COUNT_W-1:0] eff_size(input logic [TS_W-1:0] ts);
        logic [COUNT_W-1:0] s;
        if (ts == '0)
            s = COUNT_W'(1);
        else if (int'(ts) > SLOTS)
            s = COUNT_W'(SLOTS);
        else
            s = COUNT_W'(ts);
        return s;
    endfunction

endpackage
`default_nettype wire

@@ sv/dht_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dht_if
// Request and response channels of the double hash table.
// ----------------------------------------------------------------------------
interface dht_req_if;
    logic                              valid;
    logic                              ready;
    logic [dht_pkg::MODE_W-1:0]        mode;
    logic [dht_pkg::KEY_BITS-1:0]      key;
    logic [dht_pkg::PAYLOAD_BITS-1:0]  value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface dht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              success;
    logic [dht_pkg::SLOT_W-1:0]        slot_index;
    logic [dht_pkg::PAYLOAD_BITS-1:0]  found_value;
    logic [dht_pkg::COUNT_W-1:0]       entry_count;

    modport source (output valid, output success, output slot_index,
                    output found_value, output entry_count, input ready);
    modport sink   (input valid, input success, input slot_index,
                    input found_value, input entry_count, output ready);
endinterface
`default_nettype wire

@@ sv/dht_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dht_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ sv/dht_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dht_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module dht_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dht_pkg::flags_t flags,
    output      dht_pkg::act_t   act
);

    dht_pkg::pc_t    pc_reg;
    dht_pkg::pc_t    pc_next;
    dht_pkg::ucode_t word;
    logic            take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= dht_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        word = dht_pkg::ucode_rom(pc_reg);
        unique case (word.cond)
            dht_pkg::C_NEVER:       take = 1'b0;
            dht_pkg::C_NO_REQ:      take = flags.no_req;
            dht_pkg::C_MOD_MORE:    take = flags.mod_more;
            dht_pkg::C_PRE_FAIL:    take = flags.pre_fail;
            dht_pkg::C_PROBE_AGAIN: take = flags.probe_again;
            dht_pkg::C_OUT_BUSY:    take = flags.out_busy;
            default:                take = 1'b0;
        endcase
        pc_next = take ? word.jmp : word.nxt;
        act     = word.act;
    end

endmodule
`default_nettype wire

@@ sv/dht_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dht_dp
// Datapath: key remainder, probe stepping, slot store and result register.
// ----------------------------------------------------------------------------
module dht_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dht_pkg::act_t                 act,
    input  wire logic [dht_pkg::COUNT_W-1:0]   size,
    output      dht_pkg::flags_t               flags,
    dht_req_if.sink                            req,
    dht_rsp_if.source                          rsp
);

    localparam int SW = dht_pkg::SLOT_W;
    localparam int WW = dht_pkg::WRK_W;
    localparam int CW = dht_pkg::COUNT_W;
    localparam int KB = dht_pkg::KEY_BITS;
    localparam int PB = dht_pkg::PAYLOAD_BITS;
    localparam int EW = dht_pkg::ENTRY_W;

    logic [dht_pkg::MODE_W-1:0] mode_reg,  mode_next;
    logic [KB-1:0]              key_reg,   key_next;
    logic [PB-1:0]              value_reg, value_next;
    logic [SW-1:0]              rem_reg,   rem_next;
    logic [dht_pkg::BIT_W-1:0]  bit_reg,   bit_next;
    logic [SW-1:0]              j_reg,     j_next;
    logic [SW-1:0]              i_reg,     i_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [dht_pkg::SLOTS-1:0]  valid_reg, valid_next;
    logic                       res_ok_reg,  res_ok_next;
    logic [SW-1:0]              res_idx_reg, res_idx_next;
    logic [PB-1:0]              res_fv_reg,  res_fv_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_ok_reg,    out_ok_next;
    logic [SW-1:0]              out_idx_reg,   out_idx_next;
    logic [PB-1:0]              out_fv_reg,    out_fv_next;
    logic [CW-1:0]              out_cnt_reg,   out_cnt_next;

    logic                       ram_we;
    logic                       ram_re;
    logic [EW-1:0]              ram_wdata;
    logic [EW-1:0]              rd_data;

    dht_pkg::slot_state_t       rd_state;
    dht_pkg::slot_state_t       cur_state;
    logic [KB-1:0]              rd_key;
    logic [PB-1:0]              rd_payload;
    logic [WW-1:0]              size_w;
    logic [WW-1:0]              shifted;
    logic [WW-1:0]              rem_step;
    logic [WW-1:0]              h2;
    logic [WW-1:0]              jsum;
    logic [WW-1:0]              j_step;
    logic                       last_probe;
    logic                       is_ins;
    logic                       is_lookup;
    logic                       is_del;
    logic                       ins_hit;
    logic                       key_hit;
    logic                       miss_end;
    logic                       eval_done;
    logic                       pre_fail;
    logic                       out_busy;

    dht_ram #(
        .WIDTH (EW),
        .DEPTH (dht_pkg::SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (j_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        rd_state   = dht_pkg::slot_state_t'(rd_data[EW-1 -: dht_pkg::STATE_W]);
        rd_key     = rd_data[PB +: KB];
        rd_payload = rd_data[PB-1:0];
        cur_state  = valid_reg[j_reg] ? rd_state : dht_pkg::ST_EMPTY;

        size_w   = WW'(size);
        shifted  = {rem_reg, key_reg[bit_reg]};
        rem_step = (shifted >= size_w) ? shifted - size_w : shifted;
        h2       = WW'(rem_reg) + WW'(1);
        jsum     = WW'(j_reg) + h2;
        j_step   = (jsum >= size_w) ? jsum - size_w : jsum;

        last_probe = (WW'(i_reg) == size_w - WW'(1));
        is_ins     = (mode_reg == dht_pkg::MODE_INSERT);
        is_del     = (mode_reg == dht_pkg::MODE_DELETE);
        is_lookup  = (mode_reg == dht_pkg::MODE_SEARCH) || is_del;
        ins_hit    = is_ins && (cur_state != dht_pkg::ST_USED);
        key_hit    = is_lookup && (cur_state == dht_pkg::ST_USED) && (rd_key == key_reg);
        miss_end   = is_lookup && (cur_state == dht_pkg::ST_EMPTY);
        eval_done  = ins_hit || key_hit || miss_end || last_probe;

        if (is_ins)
            pre_fail = (count_reg >= size);
        else if (is_lookup)
            pre_fail = (count_reg == '0);
        else
            pre_fail = 1'b1;

        out_busy = out_valid_reg && !rsp.ready;

        flags.no_req      = !req.valid;
        flags.mod_more    = (bit_reg != '0);
        flags.pre_fail    = pre_fail;
        flags.probe_again = !eval_done;
        flags.out_busy    = out_busy;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        res_ok_next    = res_ok_reg;
        res_idx_next   = res_idx_reg;
        res_fv_next    = res_fv_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_idx_next   = out_idx_reg;
        out_fv_next    = out_fv_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = {dht_pkg::STATE_W'(dht_pkg::ST_USED), key_reg, value_reg};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (act)
            dht_pkg::A_LOAD:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    value_next = req.value;
                    rem_next   = '0;
                    bit_next   = dht_pkg::BIT_W'(KB - 1);
                end
            end
            dht_pkg::A_MOD:
            begin
                rem_next = rem_step[SW-1:0];
                bit_next = bit_reg - 1'b1;
            end
            dht_pkg::A_SETUP:
            begin
                j_next       = rem_reg;
                i_next       = '0;
                res_ok_next  = 1'b0;
                res_idx_next = '0;
                res_fv_next  = '0;
            end
            dht_pkg::A_READ:
            begin
                ram_re = 1'b1;
            end
            dht_pkg::A_EVAL:
            begin
                if (ins_hit)
                begin
                    ram_we            = 1'b1;
                    valid_next[j_reg] = 1'b1;
                    count_next        = count_reg + 1'b1;
                    res_ok_next       = 1'b1;
                    res_idx_next      = j_reg;
                end
                else if (key_hit)
                begin
                    res_ok_next  = 1'b1;
                    res_idx_next = j_reg;
                    res_fv_next  = rd_payload;
                    if (is_del)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {dht_pkg::STATE_W'(dht_pkg::ST_TOMB), rd_key, rd_payload};
                        count_next = count_reg - 1'b1;
                    end
                end
                else if (!eval_done)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = j_step[SW-1:0];
                end
            end
            dht_pkg::A_RESP:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_idx_next   = res_idx_reg;
                    out_fv_next    = res_fv_reg;
                    out_cnt_next   = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        value_reg   <= value_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        j_reg       <= j_next;
        i_reg       <= i_next;
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        res_fv_reg  <= res_fv_next;
        out_ok_reg  <= out_ok_next;
        out_idx_reg <= out_idx_next;
        out_fv_reg  <= out_fv_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign req.ready       = (act == dht_pkg::A_LOAD);
    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = out_ok_reg;
    assign rsp.slot_index  = out_idx_reg;
    assign rsp.found_value = out_fv_reg;
    assign rsp.entry_count = out_cnt_reg;

endmodule
`default_nettype wire

@@ sv/double_hash_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing hash table with double hashing, microcode sequenced.
//
// req carries one operation per beat (mode, key, value); rsp returns one
// beat per operation (success, slot_index, found_value, entry_count).
// table_size is written over the APB port at address 0 while idle.
// One operation at a time: a beat is taken, key mod size is formed one
// key bit per cycle, then each probe takes a read state and then an
// evaluate state on the single read port of the slot RAM. A failed
// precheck (full table, empty table, unused mode) skips the probes.
// The next req beat is taken once the result is in the output register.
// The response sits in an output register, so the next req beat is taken
// while rsp is stalled; a second result then waits in the sequencer until
// rsp drains. Reset empties every slot through per-slot valid flops at
// once, zeroes the entry count and sets table_size to 64.
// ----------------------------------------------------------------------------
module double_hash_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dht_pkg::APB_AW-1:0]    paddr,
    input  wire logic [dht_pkg::APB_DW-1:0]    pwdata,
    output      logic [dht_pkg::APB_DW-1:0]    prdata,
    output      logic                          pready,
    dht_req_if.sink                            req,
    dht_rsp_if.source                          rsp
);

    logic [dht_pkg::TS_W-1:0]    ts_reg;
    logic [dht_pkg::TS_W-1:0]    ts_next;
    logic [dht_pkg::COUNT_W-1:0] size;
    logic                        cfg_wr;
    dht_pkg::flags_t             flags;
    dht_pkg::act_t               act;

    always_comb
    begin
        cfg_wr  = psel && penable && pwrite;
        ts_next = ts_reg;
        if (cfg_wr && (paddr == dht_pkg::ADDR_TABLE_SIZE))
        begin
            ts_next = pwdata[dht_pkg::TS_W-1:0];
        end
        prdata = (paddr == dht_pkg::ADDR_TABLE_SIZE) ? dht_pkg::APB_DW'(ts_reg) : '0;
        pready = 1'b1;
        size   = dht_pkg::eff_size(ts_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= dht_pkg::TS_W'(dht_pkg::TS_RESET);
        end
        else
        begin
            ts_reg <= ts_next;
        end
    end

    dht_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .act   (act)
    );

    dht_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .act   (act),
        .size  (size),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.success |-> rsp.slot_index == '0 && rsp.found_value == '0)
        else $error("failed result carries slot or payload");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken on back-to-back cycles");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.entry_count <= dht_pkg::COUNT_W'(dht_pkg::SLOTS))
        else $error("entry count above slot count");

endmodule
`default_nettype wire

@@ tb/sv/dht_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_table_checker
// Watches the request, response and APB traffic of the double hash table.
// Keeps a shadow copy of the slot table and table_size, predicts the
// response of every accepted request beat and compares it field by field
// with the response beats in order.
// ----------------------------------------------------------------------------
module dht_table_checker
    import dht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    dht_req_if                  req,
    dht_rsp_if                  rsp,
    output int                  fail_count,
    output int                  results_owed
);

    typedef struct packed {
        logic                       success;
        logic [SLOT_W-1:0]          slot;
        logic [PAYLOAD_BITS-1:0]    value;
        logic [COUNT_W-1:0]         count;
    } dht_result_t;

    slot_state_t                tbl_state [SLOTS];
    logic [KEY_BITS-1:0]        tbl_key   [SLOTS];
    logic [PAYLOAD_BITS-1:0]    tbl_val   [SLOTS];
    logic [COUNT_W-1:0]         n_used;
    logic [TS_W-1:0]            cfg_ts;
    dht_result_t                owed_results [$];
    dht_result_t                want;

    initial fail_count = 0;

    task automatic report(string msg);
        $display("%0t MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    // applies one operation to the shadow table and returns its response
    function automatic dht_result_t table_op(logic [MODE_W-1:0] op,
                                             logic [KEY_BITS-1:0] k,
                                             logic [PAYLOAD_BITS-1:0] v);
        dht_result_t r;
        int span;
        int home;
        int stride;
        int s;
        int i;
        bit done;
        r = '0;
        done = 1'b0;
        if (cfg_ts == '0)
            span = 1;
        else if (int'(cfg_ts) > SLOTS)
            span = SLOTS;
        else
            span = int'(cfg_ts);
        home = int'({1'b0, k}) % span;
        stride = home + 1;
        case (op)
            MODE_INSERT:
            begin
                if (int'(n_used) < span)
                begin
                    for (i = 0; i < span && !done; i++)
                    begin
                        s = (home + i * stride) % span;
                        if (tbl_state[s] != ST_USED)
                        begin
                            tbl_state[s] = ST_USED;
                            tbl_key[s] = k;
                            tbl_val[s] = v;
                            n_used = n_used + 1'b1;
                            r.success = 1'b1;
                            r.slot = SLOT_W'(s);
                            done = 1'b1;
                        end
                    end
                end
            end
            MODE_SEARCH, MODE_DELETE:
            begin
                if (n_used != '0)
                begin
                    for (i = 0; i < span && !done; i++)
                    begin
                        s = (home + i * stride) % span;
                        if (tbl_state[s] == ST_EMPTY)
                            done = 1'b1;
                        else if (tbl_state[s] == ST_USED && tbl_key[s] == k)
                        begin
                            r.success = 1'b1;
                            r.slot = SLOT_W'(s);
                            r.value = tbl_val[s];
                            if (op == MODE_DELETE)
                            begin
                                tbl_state[s] = ST_TOMB;
                                n_used = n_used - 1'b1;
                            end
                            done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = n_used;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                tbl_state[j] = ST_EMPTY;
                tbl_key[j] = '0;
                tbl_val[j] = '0;
            end
            n_used = '0;
            cfg_ts = TS_W'(TS_RESET);
            owed_results.delete();
            results_owed <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_SIZE)
                cfg_ts = pwdata[TS_W-1:0];
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                    report($sformatf("response beat with nothing expected (slot %0d)",
                                     rsp.slot_index));
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp.success !== want.success)
                        report($sformatf("success got %0b exp %0b",
                                         rsp.success, want.success));
                    if (rsp.slot_index !== want.slot)
                        report($sformatf("slot_index got %0d exp %0d",
                                         rsp.slot_index, want.slot));
                    if (rsp.found_value !== want.value)
                        report($sformatf("found_value got %08h exp %08h",
                                         rsp.found_value, want.value));
                    if (rsp.entry_count !== want.count)
                        report($sformatf("entry_count got %0d exp %0d",
                                         rsp.entry_count, want.count));
                end
            end
            if (req.valid && req.ready)
                owed_results.push_back(table_op(req.mode, req.key, req.value));
            results_owed <= owed_results.size();
        end
    end

endmodule

@@ tb/sv/double_hash_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_tb
// Stimulus and verdict for the double hash table. A directed pass covers
// empty-table lookups, key and payload extremes, tombstone reuse, full
// table, home-slot-only probe paths and table_size clamping; random phases
// then run collision-heavy traffic over several table sizes with random
// idle bursts, one long response stall and one mid-phase drain.
// ----------------------------------------------------------------------------
module double_hash_table_tb;

    import dht_pkg::*;

    localparam logic [MODE_W-1:0]   MODE_UNUSED   = 2'd3;
    localparam logic [KEY_BITS-1:0] KEY_MAX       = '1;
    localparam int                  PHASES        = 12;
    localparam int                  PHASE_ITEMS   = 80;
    localparam int                  HOLD_LEN      = 500;
    localparam int                  STALL_LIMIT   = 3000;
    localparam int                  SETTLE_CYCLES = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int                     fail_count;
    int                     results_owed;
    int                     tx_gap_pct;
    int                     rx_gap_pct;
    int                     hold_reqs;
    int                     hold_done;
    int                     quiet_cycles;
    logic [KEY_BITS-1:0]    key_pool [$];

    dht_req_if req_ch ();
    dht_rsp_if rsp_ch ();

    double_hash_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    dht_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_op(logic [MODE_W-1:0] m, logic [KEY_BITS-1:0] k,
                           logic [PAYLOAD_BITS-1:0] v);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= m;
        req_ch.key   <= k;
        req_ch.value <= v;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // stop offering and wait for every owed response
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic write_table_size(logic [TS_W-1:0] ts);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= APB_DW'(ts);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly small keys so probe paths collide
    function automatic logic [KEY_BITS-1:0] fresh_key();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return KEY_BITS'($urandom_range(0, 255));
        else if (r < 17)
            return KEY_BITS'($urandom_range(0, 65535));
        return KEY_BITS'($urandom());
    endfunction

    task automatic send_random();
        logic [MODE_W-1:0]   m;
        logic [KEY_BITS-1:0] k;
        int                  r;
        r = $urandom_range(0, 99);
        if (r < 40)
            m = MODE_INSERT;
        else if (r < 68)
            m = MODE_SEARCH;
        else if (r < 95)
            m = MODE_DELETE;
        else
            m = MODE_UNUSED;
        if (m != MODE_INSERT && key_pool.size() > 0 && $urandom_range(0, 9) < 7)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            k = fresh_key();
        if (m == MODE_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
        send_op(m, k, $urandom());
    endtask

    // response side: random ready bursts, or one long hold when asked
    initial
    begin
        rsp_ch.ready <= 1'b0;
        hold_done = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_done++;
                rsp_ch.ready <= 1'b1;
            end
            else if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TS_W-1:0] phase_size [PHASES];
        int              p;
        int              n;
        phase_size = '{7'd64, 7'd8, 7'd1, 7'd127, 7'd3, 7'd0,
                       7'd33, 7'd64, 7'd16, 7'd100, 7'd2, 7'd64};
        tx_gap_pct = 0;
        rx_gap_pct = 20;
        hold_reqs = 0;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_INSERT;
        req_ch.key <= '0;
        req_ch.value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused mode, extremes, collisions, tombstones
        send_op(MODE_SEARCH, 31'd5, 32'h1234_5678);
        send_op(MODE_DELETE, 31'd5, '0);
        send_op(MODE_UNUSED, KEY_MAX, '1);
        send_op(MODE_INSERT, '0, '0);
        send_op(MODE_INSERT, KEY_MAX, '1);
        send_op(MODE_INSERT, 31'd64, 32'h0000_0001);
        send_op(MODE_SEARCH, 31'd64, '0);
        send_op(MODE_DELETE, '0, '0);
        send_op(MODE_SEARCH, 31'd64, '0);
        send_op(MODE_DELETE, '0, '0);
        send_op(MODE_INSERT, 31'd128, 32'hA5A5_5A5A);
        send_op(MODE_INSERT, 31'd64, 32'h0000_0002);
        send_op(MODE_SEARCH, KEY_MAX, '0);
        drain();
        // shrink to the entry count: full table, entry above size hidden
        write_table_size(7'd4);
        send_op(MODE_INSERT, 31'd1, 32'hDEAD_BEEF);
        send_op(MODE_SEARCH, KEY_MAX, '0);
        send_op(MODE_DELETE, 31'd64, '0);
        send_op(MODE_DELETE, 31'd64, '0);
        send_op(MODE_INSERT, 31'd3, 32'h5555_5555);
        send_op(MODE_INSERT, 31'd7, 32'hAAAA_AAAA);
        drain();
        write_table_size(7'd0);
        send_op(MODE_INSERT, 31'd9, 32'h0F0F_0F0F);
        send_op(MODE_SEARCH, 31'd128, '0);
        drain();
        write_table_size(7'd127);
        send_op(MODE_DELETE, 31'd128, '0);
        send_op(MODE_INSERT, 31'h4000_0000, 32'h8000_0000);
        send_op(MODE_SEARCH, 31'h4000_0000, '0);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            write_table_size(phase_size[p]);
            if (p == PHASES - 1)
            begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            else
            begin
                tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 3 && n == 30)
                    hold_reqs = hold_reqs + 1;
                if (p == 6 && n == 40)
                    drain();
                send_random();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/dht_pkg.sv
sv/dht_if.sv
sv/dht_ram.sv
sv/dht_seq.sv
sv/dht_dp.sv
sv/double_hash_table.sv
tb/sv/dht_table_checker.sv
tb/sv/double_hash_table_tb.sv
